### hdl/hrrn_pkg.sv
// ----------------------------------------------------------------------------
// hrrn_pkg
// Shared types, codes and defaults of the HRRN scheduler.
// ----------------------------------------------------------------------------
package hrrn_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	// request opcodes
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// response status codes
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_ZERO = 2'd2;

	// classified request as held in the front queue
	typedef struct packed {
		logic        opcode;
		logic [7:0]  job_id;
		logic [15:0] burst_length;
		logic        zero_burst;
	} item_t;

	// head of the front queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage

### hdl/hrrn_ifs.sv
// ----------------------------------------------------------------------------
// hrrn_ifs
// Request and response channels of the HRRN scheduler.
// ----------------------------------------------------------------------------
interface hrrn_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  job_id;
	logic [15:0] burst_length;

	modport source (output valid, output opcode, output job_id, output burst_length,
		input ready);
	modport sink (input valid, input opcode, input job_id, input burst_length,
		output ready);
endinterface

interface hrrn_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        running_valid;
	logic [7:0]  running_id;
	logic [15:0] running_left;

	modport source (output valid, output status, output running_valid,
		output running_id, output running_left, input ready);
	modport sink (input valid, input status, input running_valid,
		input running_id, input running_left, output ready);
endinterface

### hdl/hrrn_front.sv
// ----------------------------------------------------------------------------
// hrrn_front
// Accepts requests, flags zero bursts and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module hrrn_front import hrrn_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	hrrn_req_if.sink     req,
	output q_head_t      head,
	input  logic         pop
);

	item_t       fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	item_t       in_item;

	// classify the incoming request
	always_comb begin
		in_item.opcode       = req.opcode;
		in_item.job_id       = req.job_id;
		in_item.burst_length = req.burst_length;
		in_item.zero_burst   = (req.burst_length == 16'd0);
	end

	assign req.ready  = (count_q != 2'd2);
	assign push       = req.valid && req.ready;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = fifo_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= in_item;
	end

endmodule

### hdl/hrrn_engine.sv
// ----------------------------------------------------------------------------
// hrrn_engine
// Waiting table, processor state and the response-ratio selection scan.
// ----------------------------------------------------------------------------
module hrrn_engine import hrrn_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  q_head_t      head,
	output logic         pop,
	hrrn_rsp_if.source   rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// table memory
	logic [7:0]  mem_id    [TABLE_ENTRIES];
	logic [15:0] mem_burst [TABLE_ENTRIES];
	logic [31:0] mem_start [TABLE_ENTRIES];
	logic [31:0] mem_seq   [TABLE_ENTRIES];

	// control state
	logic [2:0]               state_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]         scan_idx_q;
	logic                     found_q;
	logic                     out_valid_q;
	logic [31:0]              tick_q;
	logic [31:0]              arr_q;
	logic                     run_valid_q;
	logic [7:0]               run_id_q;
	logic [15:0]              run_left_q;
	logic [IDX_W-1:0]         best_idx_q;

	// scan datapath
	logic [7:0]  rd_id_s1;
	logic [15:0] rd_burst_s1;
	logic [31:0] rd_start_s1;
	logic [31:0] rd_seq_s1;
	logic [47:0] lhs_s2;
	logic [47:0] rhs_s2;
	logic [31:0] wait_s2;
	logic [31:0] age_s2;
	logic [7:0]  best_id_q;
	logic [15:0] best_burst_q;
	logic [31:0] best_wait_q;
	logic [31:0] best_age_q;

	// output register payload
	logic [1:0]  out_status_q;
	logic        out_rv_q;
	logic [7:0]  out_id_q;
	logic [15:0] out_left_q;

	logic             out_free, is_tick, need_scan, start, scan_start;
	logic             arr_do, fast_tick, finish, commit_out, has_free, win;
	logic [IDX_W-1:0] free_idx;
	logic [1:0]       status_nx;
	logic             run_valid_nx;
	logic [7:0]       run_id_nx;
	logic [15:0]      run_left_nx;
	logic [31:0]      wait_c;

	// lowest free slot
	always_comb begin
		has_free = 1'b0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// request dispatch
	assign out_free   = !out_valid_q || rsp.ready;
	assign is_tick    = (head.item.opcode == OP_TICK);
	assign need_scan  = !run_valid_q || (run_left_q == 16'd0);
	assign start      = (state_q == ST_IDLE) && head.valid && out_free;
	assign pop        = start;
	assign arr_do     = start && !is_tick && !head.item.zero_burst && has_free;
	assign fast_tick  = start && is_tick && !need_scan;
	assign scan_start = start && is_tick && need_scan;
	assign finish     = (state_q == ST_DONE) && out_free;
	assign commit_out = (start && !scan_start) || finish;

	always_comb begin
		if (is_tick || state_q != ST_IDLE)
			status_nx = STATUS_OK;
		else if (head.item.zero_burst)
			status_nx = STATUS_ZERO;
		else if (!has_free)
			status_nx = STATUS_FULL;
		else
			status_nx = STATUS_OK;
	end

	// processor state after this request
	always_comb begin
		run_valid_nx = run_valid_q;
		run_id_nx    = run_id_q;
		run_left_nx  = run_left_q;
		if (fast_tick) begin
			run_left_nx = run_left_q - 16'd1;
		end else if (finish) begin
			if (found_q) begin
				run_valid_nx = 1'b1;
				run_id_nx    = best_id_q;
				run_left_nx  = best_burst_q - 16'd1;
			end else begin
				run_valid_nx = 1'b0;
			end
		end
	end

	// ratio compare: exact cross-multiplied form, then wait, then arrival age
	assign wait_c = tick_q - rd_start_s1;
	assign win = !found_q || (lhs_s2 > rhs_s2) ||
		((lhs_s2 == rhs_s2) && (wait_s2 > best_wait_q)) ||
		((lhs_s2 == rhs_s2) && (wait_s2 == best_wait_q) && (age_s2 > best_age_q));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			scan_idx_q  <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			tick_q      <= '0;
			arr_q       <= '0;
			run_valid_q <= 1'b0;
			run_id_q    <= '0;
			run_left_q  <= '0;
			best_idx_q  <= '0;
		end else begin
			if (commit_out)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			if (arr_do) begin
				valid_q[free_idx] <= 1'b1;
				arr_q             <= arr_q + 32'd1;
			end
			if (fast_tick || finish)
				tick_q <= tick_q + 32'd1;
			run_valid_q <= run_valid_nx;
			run_id_q    <= run_id_nx;
			run_left_q  <= run_left_nx;
			case (state_q)
				ST_IDLE: begin
					if (scan_start) begin
						scan_idx_q <= '0;
						found_q    <= 1'b0;
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					if (valid_q[scan_idx_q])
						state_q <= ST_MUL;
					else if (scan_idx_q == LAST_IDX)
						state_q <= ST_DONE;
					else
						scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (win) begin
						found_q    <= 1'b1;
						best_idx_q <= scan_idx_q;
					end
					if (scan_idx_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
						state_q    <= ST_READ;
					end
				end
				ST_DONE: begin
					if (finish) begin
						if (found_q)
							valid_q[best_idx_q] <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// table writes and registered reads
	always_ff @(posedge clk) begin
		if (arr_do) begin
			mem_id[free_idx]    <= head.item.job_id;
			mem_burst[free_idx] <= head.item.burst_length;
			mem_start[free_idx] <= tick_q;
			mem_seq[free_idx]   <= arr_q;
		end
		if (state_q == ST_READ) begin
			rd_id_s1    <= mem_id[scan_idx_q];
			rd_burst_s1 <= mem_burst[scan_idx_q];
			rd_start_s1 <= mem_start[scan_idx_q];
			rd_seq_s1   <= mem_seq[scan_idx_q];
		end
	end

	// multiply stage and best-so-far
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			lhs_s2  <= {16'd0, wait_c} * {32'd0, best_burst_q};
			rhs_s2  <= {16'd0, best_wait_q} * {32'd0, rd_burst_s1};
			wait_s2 <= wait_c;
			age_s2  <= arr_q - rd_seq_s1;
		end
		if (state_q == ST_CMP && win) begin
			best_id_q    <= rd_id_s1;
			best_burst_q <= rd_burst_s1;
			best_wait_q  <= wait_s2;
			best_age_q   <= age_s2;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (commit_out) begin
			out_status_q <= status_nx;
			out_rv_q     <= run_valid_nx;
			out_id_q     <= run_valid_nx ? run_id_nx : 8'd0;
			out_left_q   <= run_valid_nx ? run_left_nx : 16'd0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.running_valid = out_rv_q;
	assign rsp.running_id    = out_id_q;
	assign rsp.running_left  = out_left_q;

endmodule

### hdl/hrrn_scheduler.sv
// ----------------------------------------------------------------------------
// hrrn_scheduler
// Non-preemptive highest-response-ratio-next scheduler, top level.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | handshake
//  req     | in  | opcode, job_id, burst_length                     | valid/ready
//  rsp     | out | status, running_valid, running_id, running_left | valid/ready
//
// Arrivals and ticks that keep the running job are answered without a scan.
// A selecting tick walks the table: a free slot is only read, an occupied
// slot is read, multiplied and compared on the single comparator.
// A two-deep request queue and the response register let each side stall.
// Reset empties the table and the processor; no clearing pass is needed.
module hrrn_scheduler import hrrn_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hrrn_req_if.sink   req,
	hrrn_rsp_if.source rsp
);

	q_head_t head;
	logic    pop;

	hrrn_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (head),
		.pop    (pop)
	);

	hrrn_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

`ifndef NO_ASSERTIONS
	// the engine only takes a request that is there
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty queue");

	// an idle processor reports zero id and count
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.running_valid) |-> (rsp.running_id == 8'd0 &&
		rsp.running_left == 16'd0)) else $error("idle processor with data");

	// every response carries one of the three defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == STATUS_OK || rsp.status == STATUS_FULL ||
		rsp.status == STATUS_ZERO)) else $error("bad status code");
`endif

endmodule

### sim/hrrn_scheduler_tb.sv
// ----------------------------------------------------------------------------
// hrrn_scheduler_tb
// Self-checking bench for the HRRN scheduler: a directed table of requests,
// then random arrival/tick mixes checked against an in-bench scheduler model.
// ----------------------------------------------------------------------------
module hrrn_scheduler_tb;
	import hrrn_pkg::*;

	localparam int N_SLOTS = TABLE_ENTRIES_DEF;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  job_id;
		logic [15:0] burst_length;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        running_valid;
		logic [7:0]  running_id;
		logic [15:0] running_left;
	} rsp_t;

	// directed row: request plus an optional hand-written response
	typedef struct packed {
		req_t req;
		logic known;
		rsp_t rsp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hrrn_req_if req_ch ();
	hrrn_rsp_if rsp_ch ();

	hrrn_scheduler dut (.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source));

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// scheduler model state
	logic        tbl_valid [N_SLOTS];
	logic [7:0]  tbl_id    [N_SLOTS];
	logic [15:0] tbl_burst [N_SLOTS];
	logic [31:0] tbl_start [N_SLOTS];
	logic [31:0] tbl_seq   [N_SLOTS];
	logic [31:0] arrivals, ticks;
	logic        cpu_busy;
	logic [7:0]  cpu_id;
	logic [15:0] cpu_left;

	rsp_t expected_rsps [$];
	int   send_idle, recv_idle;
	bit   hold_recv;
	bit   failed;

	function automatic bit ranks_higher(int a, int b);
		logic [63:0] wa, wb, lhs, rhs;
		logic [31:0] age_a, age_b;
		wa = 64'(ticks - tbl_start[a]);
		wb = 64'(ticks - tbl_start[b]);
		lhs = wa * 64'(tbl_burst[b]);
		rhs = wb * 64'(tbl_burst[a]);
		age_a = arrivals - tbl_seq[a];
		age_b = arrivals - tbl_seq[b];
		if (lhs != rhs) return lhs > rhs;
		if (wa != wb) return wa > wb;
		return age_a > age_b;
	endfunction

	function automatic rsp_t schedule(req_t r);
		rsp_t o;
		int slot, best;
		logic [1:0] st;
		st = STATUS_OK;
		slot = -1;
		best = -1;
		if (r.opcode == OP_ARRIVE) begin
			for (int i = N_SLOTS - 1; i >= 0; i--)
				if (!tbl_valid[i]) slot = i;
			if (r.burst_length == 0) begin
				st = STATUS_ZERO;
			end else if (slot < 0) begin
				st = STATUS_FULL;
			end else begin
				tbl_valid[slot] = 1'b1;
				tbl_id[slot] = r.job_id;
				tbl_burst[slot] = r.burst_length;
				tbl_start[slot] = ticks;
				tbl_seq[slot] = arrivals;
				arrivals++;
			end
		end else begin
			if (!cpu_busy || cpu_left == 0) begin
				cpu_busy = 1'b0;
				for (int i = 0; i < N_SLOTS; i++)
					if (tbl_valid[i] && (best < 0 || ranks_higher(i, best))) best = i;
				if (best >= 0) begin
					cpu_busy = 1'b1;
					cpu_id = tbl_id[best];
					cpu_left = tbl_burst[best];
					tbl_valid[best] = 1'b0;
				end
			end
			if (cpu_busy && cpu_left != 0) cpu_left--;
			ticks++;
		end
		o.status = st;
		o.running_valid = cpu_busy;
		o.running_id = cpu_busy ? cpu_id : 8'd0;
		o.running_left = cpu_busy ? cpu_left : 16'd0;
		return o;
	endfunction

	// send one request, holding it until taken; valid drops only while idling
	task automatic send(req_t r);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= r.opcode;
		req_ch.job_id <= r.job_id;
		req_ch.burst_length <= r.burst_length;
		do @(posedge clk); while (!req_ch.ready);
		expected_rsps.push_back(schedule(r));
		@(negedge clk);
	endtask

	function automatic req_t arrive(logic [7:0] id, logic [15:0] b);
		return '{opcode: OP_ARRIVE, job_id: id, burst_length: b};
	endfunction

	function automatic req_t tick_req();
		return '{opcode: OP_TICK, job_id: 8'($urandom), burst_length: 16'($urandom)};
	endfunction

	// receiver: random stalls, plus a long hold when asked
	always @(negedge clk) begin
		if (hold_recv) rsp_ch.ready <= 1'b0;
		else rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	// response check
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_t got, exp;
			got = '{rsp_ch.status, rsp_ch.running_valid, rsp_ch.running_id,
				rsp_ch.running_left};
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response %h", $time, got);
				failed = 1'b1;
			end else begin
				exp = expected_rsps.pop_front();
				if (got !== exp) begin
					$display("%0t: mismatch expected st=%0d rv=%0d id=%0d left=%0d", $time,
						exp.status, exp.running_valid, exp.running_id, exp.running_left);
					$display("%0t:          actual   st=%0d rv=%0d id=%0d left=%0d", $time,
						got.status, got.running_valid, got.running_id, got.running_left);
					failed = 1'b1;
				end
			end
		end
	end

	// directed rows; known responses are checked against the model first
	row_t dir_rows [$];

	task automatic add_row(req_t r, logic k, rsp_t o);
		dir_rows.push_back('{req: r, known: k, rsp: o});
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			int pick;
			pick = $urandom_range(99);
			if (pick < 45) send(tick_req());
			else if (pick < 50) send(arrive(8'($urandom), 16'd0));
			else if (pick < 55)
				send(arrive(8'($urandom), 16'hFFFF - 16'($urandom_range(3))));
			else
				send(arrive(8'($urandom), 16'($urandom_range(1, (pick < 80) ? 6 : 40))));
		end
	endtask

	initial begin
		rsp_t o;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_TICK;
		req_ch.job_id = '0;
		req_ch.burst_length = '0;
		rsp_ch.ready = 1'b0;
		failed = 1'b0;
		hold_recv = 1'b0;
		send_idle = 18;
		recv_idle = 76;
		for (int i = 0; i < N_SLOTS; i++) tbl_valid[i] = 1'b0;
		arrivals = '0;
		ticks = '0;
		cpu_busy = 1'b0;
		cpu_id = '0;
		cpu_left = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idle tick, zero burst, extremes, finish and reselect
		add_row(tick_req(), 1'b1, '{STATUS_OK, 1'b0, 8'd0, 16'd0});
		add_row(arrive(8'hFF, 16'd0), 1'b1, '{STATUS_ZERO, 1'b0, 8'd0, 16'd0});
		add_row(arrive(8'h00, 16'd1), 1'b1, '{STATUS_OK, 1'b0, 8'd0, 16'd0});
		add_row(tick_req(), 1'b1, '{STATUS_OK, 1'b1, 8'h00, 16'd0});
		add_row(arrive(8'hFF, 16'hFFFF), 1'b1, '{STATUS_OK, 1'b1, 8'h00, 16'd0});
		add_row(arrive(8'hAA, 16'd2), 1'b0, '0);
		add_row(arrive(8'h55, 16'd2), 1'b0, '0);
		add_row(tick_req(), 1'b0, '0);
		add_row(tick_req(), 1'b0, '0);
		add_row(tick_req(), 1'b0, '0);
		add_row(tick_req(), 1'b0, '0);
		foreach (dir_rows[k]) begin
			o = schedule(dir_rows[k].req);
			if (dir_rows[k].known && o !== dir_rows[k].rsp) begin
				$display("%0t: row %0d expected %h actual %h", $time, k,
					dir_rows[k].rsp, o);
				failed = 1'b1;
			end
			dir_rows[k].rsp = o;
		end
		// roll model back: reset state then replay through the driver
		for (int i = 0; i < N_SLOTS; i++) tbl_valid[i] = 1'b0;
		arrivals = '0;
		ticks = '0;
		cpu_busy = 1'b0;
		foreach (dir_rows[k]) send(dir_rows[k].req);
		// fill the table until full is refused
		for (int i = 0; i < N_SLOTS + 2; i++) send(arrive(8'(i), 16'(i + 1)));

		random_phase(110);
		send_idle = 76;
		recv_idle = 18;
		random_phase(110);
		send_idle = 0;
		recv_idle = 0;
		// receiver holds off while requests keep coming
		fork
			begin
				hold_recv = 1'b1;
				repeat (300) @(negedge clk);
				hold_recv = 1'b0;
			end
			random_phase(12);
		join
		random_phase(140);
		req_ch.valid <= 1'b0;

		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (!failed) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#8000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
hdl/hrrn_pkg.sv
hdl/hrrn_ifs.sv
hdl/hrrn_front.sv
hdl/hrrn_engine.sv
hdl/hrrn_scheduler.sv
sim/hrrn_scheduler_tb.sv
